// ===== rtl/pls_pkg.sv =====
// pls_pkg: widths, register map, term codes and shared types of the
// periodic Laplacian stencil generator. No dependencies.
package pls_pkg;

  // Field widths
  localparam int COORD_W = 10;
  localparam int SIZE_W  = 11;
  localparam int IDX_W   = 30;
  localparam int COEF_W  = 34;
  localparam int WGT_W   = 32;

  // Intermediate widths of the index arithmetic
  localparam int PROD_W = SIZE_W + COORD_W;  // size_y * z
  localparam int SUM_W  = PROD_W + 1;        // y + size_y * z
  localparam int MUL_W  = SIZE_W + SUM_W;    // size_x * (y + size_y * z)

  // Largest grid dimension; larger sizes saturate to it
  localparam int MAX_DIM = 1024;
  localparam logic [SIZE_W-1:0] MAX_DIM_SZ = SIZE_W'(MAX_DIM);

  // Configuration port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_SIZE_X = 3'd0,
    REG_SIZE_Y = 3'd1,
    REG_SIZE_Z = 3'd2,
    REG_INV_DX = 3'd3,
    REG_INV_DY = 3'd4,
    REG_INV_DZ = 3'd5
  } reg_idx_t;

  // Position of the current term within one axis
  typedef enum logic [2:0] {
    POS_LO  = 3'b001,
    POS_MID = 3'b010,
    POS_HI  = 3'b100
  } term_pos_t;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Index pipeline result: products sx*(...) for centre, y-, y+, z-, z+
  typedef struct packed {
    logic                     err;
    logic [COORD_W-1:0]       x;
    logic [COORD_W-1:0]       xl;
    logic [COORD_W-1:0]       xr;
    logic [4:0][IDX_W-1:0]    m;
  } pls_prod_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    return (s > MAX_DIM_SZ) ? MAX_DIM_SZ : s;
  endfunction

endpackage

// ===== rtl/pls_if.sv =====
// pls_in_if / pls_out_if: valid/ready channels of the stencil generator.
// Depends on pls_pkg for field widths.
interface pls_in_if;
  logic                          valid;
  logic                          ready;
  logic [pls_pkg::COORD_W-1:0]   coord_x;
  logic [pls_pkg::COORD_W-1:0]   coord_y;
  logic [pls_pkg::COORD_W-1:0]   coord_z;

  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface pls_out_if;
  logic                              valid;
  logic                              ready;
  logic [pls_pkg::IDX_W-1:0]         row_index;
  logic [pls_pkg::IDX_W-1:0]         col_index;
  logic signed [pls_pkg::COEF_W-1:0] coefficient;
  logic                              coord_error;
  logic                              last_term;

  modport source (output valid, row_index, col_index, coefficient, coord_error,
                  last_term, input ready);
  modport sink   (input valid, row_index, col_index, coefficient, coord_error,
                  last_term, output ready);
endinterface

// ===== rtl/periodic_laplacian_stencil_gen.sv =====
// periodic_laplacian_stencil_gen: nine-triplet Laplacian rows of a periodic grid.
// An accepted point goes through the four index stages, the serializer and the output
// register. Triplets leave one per cycle while out_ch.ready is high; a point gives
//   nine (one for an out-of-range point), and the single result port sets the rate.
// Index math is a 4-stage pipeline that takes a request every cycle when free.
// Reset (rst_n, synchronous): sizes 1, inverse spacings 0, all pipeline valids cleared.
module periodic_laplacian_stencil_gen (
  input  logic                         clk,
  input  logic                         rst_n,
  pls_in_if.sink                       in_ch,
  pls_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pls_pkg::ADDR_W-1:0]   paddr,
  input  logic [pls_pkg::DATA_W-1:0]   pwdata,
  output logic [pls_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  // configuration registers
  logic [pls_pkg::SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [pls_pkg::WGT_W-1:0]  inv_dx_r, inv_dy_r, inv_dz_r;
  logic                       cfg_wr;
  pls_pkg::reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = pls_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= pls_pkg::SIZE_W'(1);
      size_y_r <= pls_pkg::SIZE_W'(1);
      size_z_r <= pls_pkg::SIZE_W'(1);
      inv_dx_r <= '0;
      inv_dy_r <= '0;
      inv_dz_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        pls_pkg::REG_SIZE_X: size_x_r <= pwdata[pls_pkg::SIZE_W-1:0];
        pls_pkg::REG_SIZE_Y: size_y_r <= pwdata[pls_pkg::SIZE_W-1:0];
        pls_pkg::REG_SIZE_Z: size_z_r <= pwdata[pls_pkg::SIZE_W-1:0];
        pls_pkg::REG_INV_DX: inv_dx_r <= pwdata;
        pls_pkg::REG_INV_DY: inv_dy_r <= pwdata;
        pls_pkg::REG_INV_DZ: inv_dz_r <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      pls_pkg::REG_SIZE_X: prdata = pls_pkg::DATA_W'(size_x_r);
      pls_pkg::REG_SIZE_Y: prdata = pls_pkg::DATA_W'(size_y_r);
      pls_pkg::REG_SIZE_Z: prdata = pls_pkg::DATA_W'(size_z_r);
      pls_pkg::REG_INV_DX: prdata = inv_dx_r;
      pls_pkg::REG_INV_DY: prdata = inv_dy_r;
      pls_pkg::REG_INV_DZ: prdata = inv_dz_r;
      default:             prdata = '0;
    endcase
  end

  // index pipeline
  logic               pipe_valid;
  logic               ser_free;
  pls_pkg::pls_prod_t pipe_data;

  pls_index_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .coord_x   (in_ch.coord_x),
    .coord_y   (in_ch.coord_y),
    .coord_z   (in_ch.coord_z),
    .size_x    (size_x_r),
    .size_y    (size_y_r),
    .size_z    (size_z_r),
    .out_valid (pipe_valid),
    .out_ready (ser_free),
    .out_data  (pipe_data)
  );

  // term serializer: holds one point's indices, walks nine terms (one for an error point)
  logic                            ser_valid_r;
  logic                            ser_err_r;
  logic [pls_pkg::IDX_W-1:0]       ser_row_r;
  logic [2:0][pls_pkg::IDX_W-1:0]  ser_lo_r, ser_hi_r;
  pls_pkg::term_pos_t              pos_r;
  logic [1:0]                      axis_r;

  logic                            out_valid_r;
  logic                            out_load;
  logic                            is_last;
  logic [pls_pkg::WGT_W-1:0]       wgt;
  logic [pls_pkg::IDX_W-1:0]       col_nxt;
  logic [pls_pkg::COEF_W-1:0]      coef_nxt;
  logic [pls_pkg::IDX_W-1:0]       out_row_r, out_col_r;
  logic [pls_pkg::COEF_W-1:0]      out_coef_r;
  logic                            out_err_r, out_last_r;

  assign out_load = !out_valid_r || out_ch.ready;
  assign is_last  = ser_err_r || ((axis_r == pls_pkg::AXIS_Z) && (pos_r == pls_pkg::POS_HI));
  assign ser_free = !ser_valid_r || (out_load && is_last);

  // current term's column and weight
  always_comb begin
    case (axis_r)
      pls_pkg::AXIS_X: wgt = inv_dx_r;
      pls_pkg::AXIS_Y: wgt = inv_dy_r;
      default:         wgt = inv_dz_r;
    endcase
    case (pos_r)
      pls_pkg::POS_LO: begin
        col_nxt  = ser_lo_r[axis_r];
        coef_nxt = {2'b00, wgt};
      end
      pls_pkg::POS_MID: begin
        col_nxt  = ser_row_r;
        coef_nxt = pls_pkg::COEF_W'(0) - {1'b0, wgt, 1'b0};
      end
      default: begin
        col_nxt  = ser_hi_r[axis_r];
        coef_nxt = {2'b00, wgt};
      end
    endcase
  end

  // serializer control; a new point replaces the one whose last term leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
      pos_r       <= pls_pkg::POS_LO;
      axis_r      <= pls_pkg::AXIS_X;
    end else if (pipe_valid && ser_free) begin
      ser_valid_r <= 1'b1;
      pos_r       <= pls_pkg::POS_LO;
      axis_r      <= pls_pkg::AXIS_X;
    end else if (ser_valid_r && out_load) begin
      if (is_last) begin
        ser_valid_r <= 1'b0;
      end else begin
        case (pos_r)
          pls_pkg::POS_LO:  pos_r <= pls_pkg::POS_MID;
          pls_pkg::POS_MID: pos_r <= pls_pkg::POS_HI;
          default: begin
            pos_r  <= pls_pkg::POS_LO;
            axis_r <= axis_r + 2'd1;
          end
        endcase
      end
    end
  end

  // serializer payload: add x terms to the products
  always_ff @(posedge clk) begin
    if (pipe_valid && ser_free) begin
      ser_err_r   <= pipe_data.err;
      ser_row_r   <= pls_pkg::IDX_W'(pipe_data.x)  + pipe_data.m[0];
      ser_lo_r[0] <= pls_pkg::IDX_W'(pipe_data.xl) + pipe_data.m[0];
      ser_hi_r[0] <= pls_pkg::IDX_W'(pipe_data.xr) + pipe_data.m[0];
      ser_lo_r[1] <= pls_pkg::IDX_W'(pipe_data.x)  + pipe_data.m[1];
      ser_hi_r[1] <= pls_pkg::IDX_W'(pipe_data.x)  + pipe_data.m[2];
      ser_lo_r[2] <= pls_pkg::IDX_W'(pipe_data.x)  + pipe_data.m[3];
      ser_hi_r[2] <= pls_pkg::IDX_W'(pipe_data.x)  + pipe_data.m[4];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= ser_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && ser_valid_r) begin
      out_err_r  <= ser_err_r;
      out_last_r <= is_last;
      if (ser_err_r) begin
        out_row_r  <= '0;
        out_col_r  <= '0;
        out_coef_r <= '0;
      end else begin
        out_row_r  <= ser_row_r;
        out_col_r  <= col_nxt;
        out_coef_r <= coef_nxt;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.row_index   = out_row_r;
  assign out_ch.col_index   = out_col_r;
  assign out_ch.coefficient = out_coef_r;
  assign out_ch.coord_error = out_err_r;
  assign out_ch.last_term   = out_last_r;

  // an error result is a single, final, all-zero triplet
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.coord_error |->
      out_ch.last_term && (out_ch.row_index == '0) && (out_ch.coefficient == '0))
    else $error("error result not a lone zero triplet");

  // the z-right term of a good point closes the point
  a_last_on_z_hi: assert property (@(posedge clk) disable iff (!rst_n)
    ser_valid_r && !ser_err_r && out_load && (axis_r == pls_pkg::AXIS_Z) &&
      (pos_r == pls_pkg::POS_HI) |=> out_ch.valid && out_ch.last_term)
    else $error("z-right term not marked last");

  // a point's terms are not broken by another point's error result
  a_no_err_midpoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_term |=>
      !out_ch.valid || !out_ch.coord_error)
    else $error("error result inside a point's terms");

endmodule

// ===== rtl/pls_index_pipe.sv =====
// pls_index_pipe: four-stage pipeline from point coordinates to the five
// size_x*(y + size_y*z) products that the seven indices use. Depends on pls_pkg.
module pls_index_pipe (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pls_pkg::COORD_W-1:0]  coord_x,
  input  logic [pls_pkg::COORD_W-1:0]  coord_y,
  input  logic [pls_pkg::COORD_W-1:0]  coord_z,
  input  logic [pls_pkg::SIZE_W-1:0]   size_x,
  input  logic [pls_pkg::SIZE_W-1:0]   size_y,
  input  logic [pls_pkg::SIZE_W-1:0]   size_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pls_pkg::pls_prod_t           out_data
);

  // wrap-around neighbours
  function automatic logic [pls_pkg::COORD_W-1:0] wrap_dn(
    input logic [pls_pkg::COORD_W-1:0] c,
    input logic [pls_pkg::SIZE_W-1:0]  s
  );
    logic [pls_pkg::SIZE_W-1:0] sm1;
    sm1 = s - pls_pkg::SIZE_W'(1);
    return (c == '0) ? sm1[pls_pkg::COORD_W-1:0] : c - pls_pkg::COORD_W'(1);
  endfunction

  function automatic logic [pls_pkg::COORD_W-1:0] wrap_up(
    input logic [pls_pkg::COORD_W-1:0] c,
    input logic [pls_pkg::SIZE_W-1:0]  s
  );
    logic [pls_pkg::SIZE_W-1:0] sm1;
    sm1 = s - pls_pkg::SIZE_W'(1);
    return ({1'b0, c} == sm1) ? '0 : c + pls_pkg::COORD_W'(1);
  endfunction

  // stage valids and ready chain
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: range check and neighbour coordinates
  logic [pls_pkg::SIZE_W-1:0]  sx_c, sy_c, sz_c;
  logic                        s1_err_nxt;
  logic                        s1_err_r;
  logic [pls_pkg::COORD_W-1:0] s1_x_r, s1_xl_r, s1_xr_r;
  logic [pls_pkg::COORD_W-1:0] s1_y_r, s1_yl_r, s1_yr_r;
  logic [pls_pkg::COORD_W-1:0] s1_z_r, s1_zl_r, s1_zr_r;
  logic [pls_pkg::SIZE_W-1:0]  s1_sx_r, s1_sy_r;

  always_comb begin
    sx_c = pls_pkg::clamp_size(size_x);
    sy_c = pls_pkg::clamp_size(size_y);
    sz_c = pls_pkg::clamp_size(size_z);
    s1_err_nxt = ({1'b0, coord_x} >= sx_c) || ({1'b0, coord_y} >= sy_c) ||
                 ({1'b0, coord_z} >= sz_c);
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_err_r <= s1_err_nxt;
      s1_x_r   <= coord_x;
      s1_xl_r  <= wrap_dn(coord_x, sx_c);
      s1_xr_r  <= wrap_up(coord_x, sx_c);
      s1_y_r   <= coord_y;
      s1_yl_r  <= wrap_dn(coord_y, sy_c);
      s1_yr_r  <= wrap_up(coord_y, sy_c);
      s1_z_r   <= coord_z;
      s1_zl_r  <= wrap_dn(coord_z, sz_c);
      s1_zr_r  <= wrap_up(coord_z, sz_c);
      s1_sx_r  <= sx_c;
      s1_sy_r  <= sy_c;
    end
  end

  // stage 2: size_y * z for z, z-1, z+1
  logic                        s2_err_r;
  logic [pls_pkg::COORD_W-1:0] s2_x_r, s2_xl_r, s2_xr_r;
  logic [pls_pkg::COORD_W-1:0] s2_y_r, s2_yl_r, s2_yr_r;
  logic [pls_pkg::SIZE_W-1:0]  s2_sx_r;
  logic [pls_pkg::PROD_W-1:0]  s2_pz_r, s2_pzl_r, s2_pzr_r;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      s2_err_r <= s1_err_r;
      s2_x_r   <= s1_x_r;
      s2_xl_r  <= s1_xl_r;
      s2_xr_r  <= s1_xr_r;
      s2_y_r   <= s1_y_r;
      s2_yl_r  <= s1_yl_r;
      s2_yr_r  <= s1_yr_r;
      s2_sx_r  <= s1_sx_r;
      s2_pz_r  <= pls_pkg::PROD_W'(s1_sy_r) * pls_pkg::PROD_W'(s1_z_r);
      s2_pzl_r <= pls_pkg::PROD_W'(s1_sy_r) * pls_pkg::PROD_W'(s1_zl_r);
      s2_pzr_r <= pls_pkg::PROD_W'(s1_sy_r) * pls_pkg::PROD_W'(s1_zr_r);
    end
  end

  // stage 3: add the y term (centre, y-, y+, z-, z+)
  logic                            s3_err_r;
  logic [pls_pkg::COORD_W-1:0]     s3_x_r, s3_xl_r, s3_xr_r;
  logic [pls_pkg::SIZE_W-1:0]      s3_sx_r;
  logic [4:0][pls_pkg::SUM_W-1:0]  s3_a_r;

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      s3_err_r  <= s2_err_r;
      s3_x_r    <= s2_x_r;
      s3_xl_r   <= s2_xl_r;
      s3_xr_r   <= s2_xr_r;
      s3_sx_r   <= s2_sx_r;
      s3_a_r[0] <= pls_pkg::SUM_W'(s2_y_r)  + pls_pkg::SUM_W'(s2_pz_r);
      s3_a_r[1] <= pls_pkg::SUM_W'(s2_yl_r) + pls_pkg::SUM_W'(s2_pz_r);
      s3_a_r[2] <= pls_pkg::SUM_W'(s2_yr_r) + pls_pkg::SUM_W'(s2_pz_r);
      s3_a_r[3] <= pls_pkg::SUM_W'(s2_y_r)  + pls_pkg::SUM_W'(s2_pzl_r);
      s3_a_r[4] <= pls_pkg::SUM_W'(s2_y_r)  + pls_pkg::SUM_W'(s2_pzr_r);
    end
  end

  // stage 4: multiply by size_x, keep the low index bits
  logic [4:0][pls_pkg::MUL_W-1:0] s4_p;
  pls_pkg::pls_prod_t             s4_nxt, s4_r;

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      s4_p[k] = pls_pkg::MUL_W'(s3_sx_r) * pls_pkg::MUL_W'(s3_a_r[k]);
    end
    s4_nxt.err = s3_err_r;
    s4_nxt.x   = s3_x_r;
    s4_nxt.xl  = s3_xl_r;
    s4_nxt.xr  = s3_xr_r;
    for (int k = 0; k < 5; k++) begin
      s4_nxt.m[k] = s4_p[k][pls_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      s4_r <= s4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = s4_r;

endmodule

// ===== bench/tb_periodic_laplacian_stencil_gen.sv =====
// Testbench of periodic_laplacian_stencil_gen: directed and random grid points,
// with an in-bench predictor of the nine-term Laplacian row and a result checker.
// Depends on pls_pkg and the pls_in_if / pls_out_if interfaces of the RTL.
`timescale 1ns / 1ps

module tb_periodic_laplacian_stencil_gen;

  localparam int NUM_REGS     = 6;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 165;

  typedef logic [pls_pkg::COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [pls_pkg::IDX_W-1:0]  row;
    logic [pls_pkg::IDX_W-1:0]  col;
    logic [pls_pkg::COEF_W-1:0] coef;
    logic                       err;
    logic                       last;
  } stencil_term_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [pls_pkg::ADDR_W-1:0] paddr;
  logic [pls_pkg::DATA_W-1:0] pwdata;
  logic [pls_pkg::DATA_W-1:0] prdata;
  logic pready;

  pls_in_if  in_bus ();
  pls_out_if out_bus ();

  periodic_laplacian_stencil_gen dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the register file
  logic [pls_pkg::SIZE_W-1:0] grid_size [3];
  logic [pls_pkg::WGT_W-1:0]  grid_wgt  [3];

  stencil_term_t pending_terms [$];
  int  mismatches = 0;
  bit  idle_on    = 1'b1;
  int  stall_left = 0;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit, well above the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Mostly short gaps, a few long ones, none while idling is off
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint unsigned eff_size(input logic [pls_pkg::SIZE_W-1:0] s);
    return (s > pls_pkg::MAX_DIM_SZ) ? 64'(pls_pkg::MAX_DIM_SZ) : 64'(s);
  endfunction

  function automatic logic [pls_pkg::IDX_W-1:0] linear_index(
    input longint unsigned px, py, pz,
    input longint unsigned sx, sy
  );
    return pls_pkg::IDX_W'(px + sx * (py + sy * pz));
  endfunction

  // Queue one expected term at the tail
  function automatic void expect_term(input stencil_term_t t);
    pending_terms = {pending_terms, t};
  endfunction

  // Expected terms of one grid point: x, y, z axes, each as left, centre, right
  function automatic void predict_stencil_row(input coord_t x, y, z);
    longint unsigned pos [3];
    longint unsigned nb  [3];
    longint unsigned eff [3];
    logic [pls_pkg::IDX_W-1:0]  centre;
    logic [pls_pkg::IDX_W-1:0]  lo;
    logic [pls_pkg::IDX_W-1:0]  hi;
    logic [pls_pkg::COEF_W-1:0] wgt;
    logic [pls_pkg::COEF_W-1:0] mid;
    pos[0] = 64'(x);
    pos[1] = 64'(y);
    pos[2] = 64'(z);
    for (int a = 0; a < 3; a++) eff[a] = eff_size(grid_size[a]);
    if (pos[0] >= eff[0] || pos[1] >= eff[1] || pos[2] >= eff[2]) begin
      expect_term('{row: '0, col: '0, coef: '0, err: 1'b1, last: 1'b1});
      return;
    end
    centre = linear_index(pos[0], pos[1], pos[2], eff[0], eff[1]);
    for (int a = 0; a < 3; a++) begin
      nb = pos;
      nb[a] = (pos[a] == 0) ? eff[a] - 1 : pos[a] - 1;
      lo = linear_index(nb[0], nb[1], nb[2], eff[0], eff[1]);
      nb[a] = (pos[a] == eff[a] - 1) ? 0 : pos[a] + 1;
      hi = linear_index(nb[0], nb[1], nb[2], eff[0], eff[1]);
      wgt = pls_pkg::COEF_W'(grid_wgt[a]);
      mid = pls_pkg::COEF_W'(0) - (wgt << 1);
      expect_term('{row: centre, col: lo, coef: wgt, err: 1'b0, last: 1'b0});
      expect_term('{row: centre, col: centre, coef: mid, err: 1'b0, last: 1'b0});
      expect_term('{row: centre, col: hi, coef: wgt, err: 1'b0, last: a == 2});
    end
  endfunction

  function automatic logic [pls_pkg::DATA_W-1:0] reg_value(input int idx);
    if (idx <= int'(pls_pkg::REG_SIZE_Z)) return pls_pkg::DATA_W'(grid_size[idx]);
    return grid_wgt[idx - int'(pls_pkg::REG_INV_DX)];
  endfunction

  // Result side: random stalls on ready
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_bus.ready = 1'b0;
      stall_left--;
    end else begin
      out_bus.ready = 1'b1;
      stall_left = idle_cycles();
    end
  end

  task automatic report_field(input string name, input logic [63:0] want, got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare every accepted result with the oldest expected term
  always @(posedge clk) begin
    stencil_term_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_terms.size() == 0) begin
        $display("%0t unexpected result: expected none, actual row %h col %h coef %h",
                 $time, out_bus.row_index, out_bus.col_index, out_bus.coefficient);
        mismatches++;
      end else begin
        want = pending_terms.pop_front();
        report_field("row_index",   64'(want.row),  64'(out_bus.row_index));
        report_field("col_index",   64'(want.col),  64'(out_bus.col_index));
        report_field("coefficient", 64'(want.coef),
                     64'($unsigned(out_bus.coefficient)));
        report_field("coord_error", 64'(want.err),  64'(out_bus.coord_error));
        report_field("last_term",   64'(want.last), 64'(out_bus.last_term));
      end
    end
  end

  // One point request; valid stays high for a following request with no gap
  task automatic send_point(input coord_t x, y, z);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid   = 1'b1;
    in_bus.coord_x = x;
    in_bus.coord_y = y;
    in_bus.coord_z = z;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    predict_stencil_row(x, y, z);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB transfer: setup cycle, then access cycle completing on pready
  task automatic cfg_access(input int idx, input bit wr,
                            input logic [pls_pkg::DATA_W-1:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = pls_pkg::ADDR_W'(idx * 4);
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (!wr && idx < NUM_REGS)
      report_field($sformatf("register %0d", idx), 64'(reg_value(idx)), 64'(prdata));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic cfg_write(input int idx, input logic [pls_pkg::DATA_W-1:0] val);
    cfg_access(idx, 1'b1, val);
    if (idx <= int'(pls_pkg::REG_SIZE_Z))
      grid_size[idx] = val[pls_pkg::SIZE_W-1:0];
    else if (idx <= int'(pls_pkg::REG_INV_DZ))
      grid_wgt[idx - int'(pls_pkg::REG_INV_DX)] = val;
  endtask

  task automatic read_back_all();
    for (int i = 0; i < NUM_REGS; i++) cfg_access(i, 1'b0, '0);
  endtask

  // Reconfigure only once the block has gone quiet
  task automatic set_grid(input logic [pls_pkg::DATA_W-1:0] sx, sy, sz, wx, wy, wz);
    idle_input();
    wait_drained();
    cfg_write(int'(pls_pkg::REG_SIZE_X), sx);
    cfg_write(int'(pls_pkg::REG_SIZE_Y), sy);
    cfg_write(int'(pls_pkg::REG_SIZE_Z), sz);
    cfg_write(int'(pls_pkg::REG_INV_DX), wx);
    cfg_write(int'(pls_pkg::REG_INV_DY), wy);
    cfg_write(int'(pls_pkg::REG_INV_DZ), wz);
    read_back_all();
  endtask

  function automatic logic [pls_pkg::DATA_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(1, 8);
    if (r < 70) return $urandom_range(9, 64);
    if (r < 85) return $urandom_range(65, pls_pkg::MAX_DIM);
    if (r < 92) return $urandom_range(pls_pkg::MAX_DIM + 1, 2047);
    if (r < 95) return 0;
    return pls_pkg::MAX_DIM;
  endfunction

  function automatic logic [pls_pkg::DATA_W-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 30) return pls_pkg::DATA_W'(1) << $urandom_range(0, 31);
    return $urandom;
  endfunction

  // Mostly in range with the faces favored; the rest is any 10-bit value
  function automatic coord_t pick_coord(input logic [pls_pkg::SIZE_W-1:0] s);
    longint unsigned eff;
    int r;
    eff = eff_size(s);
    r = $urandom_range(0, 99);
    if (eff == 0 || r >= 88) return coord_t'($urandom_range(0, pls_pkg::MAX_DIM - 1));
    if (r < 15) return '0;
    if (r < 30) return coord_t'(eff - 1);
    return coord_t'($urandom_range(0, int'(eff) - 1));
  endfunction

  task automatic send_random_point();
    send_point(pick_coord(grid_size[0]), pick_coord(grid_size[1]),
               pick_coord(grid_size[2]));
  endtask

  // ---------------------------------------------------------------- tests

  // Reset values: one-point grid, zero weights
  task automatic test_reset_state();
    read_back_all();
    send_point(0, 0, 0);
    send_point(1, 0, 0);
  endtask

  // Largest grid, extreme weights and coordinates
  task automatic test_full_grid();
    set_grid(pls_pkg::MAX_DIM, pls_pkg::MAX_DIM, pls_pkg::MAX_DIM, '1, 1, 32'h8000_0000);
    send_point(0, 0, 0);
    send_point(1023, 1023, 1023);
    send_point(1023, 0, 1023);
    send_point(0, 1023, 0);
    send_point(341, 682, 512);
  endtask

  // Sizes above the maximum saturate
  task automatic test_size_saturation();
    set_grid(2047, pls_pkg::MAX_DIM + 1, 1500, 32'h0001_0000, '1, 32'h0000_8000);
    send_point(1023, 1023, 1023);
    send_point(0, 512, 1023);
  endtask

  // Each coordinate at or past its size gives the single error term; an in-range corner gives nine
  task automatic test_out_of_range();
    set_grid(5, 7, 3, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000);
    send_point(5, 0, 0);
    send_point(0, 7, 0);
    send_point(0, 0, 3);
    send_point(4, 6, 2);
    send_point(1023, 1023, 1023);
    send_point(4, 7, 2);
  endtask

  // A zero size puts every point out of range
  task automatic test_zero_size();
    set_grid(0, 4, 4, 1, 2, 3);
    send_point(0, 0, 0);
    send_point(0, 3, 3);
    set_grid(4, 4, 0, 1, 2, 3);
    send_point(0, 0, 0);
  endtask

  // Size one: both neighbours are the point itself
  task automatic test_unit_size();
    set_grid(1, 2, 1, 32'hDEAD_BEEF, 32'h1234_5678, '1);
    send_point(0, 0, 0);
    send_point(0, 1, 0);
  endtask

  // Writes past the register map leave every register alone
  task automatic test_unmapped_write();
    idle_input();
    wait_drained();
    cfg_write(NUM_REGS, '1);
    cfg_write(NUM_REGS + 1, 32'h0000_0003);
    read_back_all();
    send_point(0, 1, 0);
  endtask

  // Full rate on both sides
  task automatic test_back_to_back();
    set_grid(16, 8, 4, pick_weight(), pick_weight(), pick_weight());
    idle_on = 1'b0;
    repeat (20) send_random_point();
    idle_input();
    wait_drained();
    idle_on = 1'b1;
  endtask

  // Random grids, each followed by a burst of random points
  task automatic test_random_grids();
    int sent;
    int n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_grid(pick_size(), pick_size(), pick_size(),
               pick_weight(), pick_weight(), pick_weight());
      idle_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(10, 30);
      repeat (n) send_random_point();
      sent += n;
    end
    idle_input();
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_bus.valid   = 1'b0;
    in_bus.coord_x = '0;
    in_bus.coord_y = '0;
    in_bus.coord_z = '0;
    for (int a = 0; a < 3; a++) begin
      grid_size[a] = pls_pkg::SIZE_W'(1);
      grid_wgt[a]  = '0;
    end
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_full_grid();
    test_size_saturation();
    test_out_of_range();
    test_zero_size();
    test_unit_size();
    test_unmapped_write();
    test_back_to_back();
    test_random_grids();

    idle_input();
    wait_drained();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
